/* sv/ahat_pkg.sv */
package ahat_pkg;

    // Rotation datapath: word width, digit width and digit count
    localparam int CW         = 48;
    localparam int DIGIT      = 8;
    localparam int NDIG       = CW / DIGIT;
    localparam int DIG_IDX_W  = $clog2(NDIG);
    localparam int BIT_IDX_W  = $clog2(CW);
    localparam int POS_W      = BIT_IDX_W + 1;
    localparam int STEP_IDX_W = 5;
    localparam int VEC_SCALE  = 30;

    // Angle units are 1e-12 degree
    localparam logic [CW-1:0] ANGLE_UNIT  = 48'd1000000000000;
    localparam logic [63:0]   DEG_PER_RAD = 64'd57295779513082;
    localparam int            QUOT_BITS   = 7;
    localparam int            QCNT_W      = $clog2(QUOT_BITS);
    localparam logic [CW-1:0] DIV_TOP     = ANGLE_UNIT << (QUOT_BITS - 1);
    localparam int            DEG_W       = 6;
    localparam int            MAX_PHI_DEG = 44;

    // Deadzone scaling: radius times 100, squared
    localparam int DZ_SCALE = 10000;

    // Hat composition
    localparam logic [15:0] HAT_CENTER = 16'hFFFF;
    localparam logic [15:0] HAT_SCALE  = 16'd100;
    localparam logic [6:0]  FA_45      = 7'd45;
    localparam logic [6:0]  FA_89      = 7'd89;
    localparam logic [6:0]  FA_90      = 7'd90;
    localparam logic [8:0]  ANG_90     = 9'd90;
    localparam logic [8:0]  ANG_180    = 9'd180;
    localparam logic [8:0]  ANG_360    = 9'd360;

    typedef struct packed {
        logic done;
        logic center;
    } dz_stat_t;

    typedef struct packed {
        logic             done;
        logic [DEG_W-1:0] deg;
    } cd_stat_t;

    // atan(2^-i) in 1e-12 degree
    function automatic logic [CW-1:0] atan_step(input logic [STEP_IDX_W-1:0] i);
        logic [63:0] tmp;
        tmp = '0;
        case (i)
            5'd0:    atan_step = 48'd45000000000000;
            5'd1:    atan_step = 48'd26565051177078;
            5'd2:    atan_step = 48'd14036243467926;
            5'd3:    atan_step = 48'd7125016348902;
            5'd4:    atan_step = 48'd3576334374997;
            5'd5:    atan_step = 48'd1789910608246;
            5'd6:    atan_step = 48'd895173710211;
            5'd7:    atan_step = 48'd447614170861;
            5'd8:    atan_step = 48'd223810500369;
            5'd9:    atan_step = 48'd111905677066;
            5'd10:   atan_step = 48'd55952891894;
            5'd11:   atan_step = 48'd27976452617;
            5'd12:   atan_step = 48'd13988227142;
            5'd13:   atan_step = 48'd6994113675;
            5'd14:   atan_step = 48'd3497056851;
            5'd15:   atan_step = 48'd1748528427;
            default:
            begin
                tmp = (DEG_PER_RAD + (64'd1 << (i - STEP_IDX_W'(1)))) >> i;
                atan_step = tmp[CW-1:0];
            end
        endcase
    endfunction

endpackage

/* sv/ahat_dzone.sv */
module ahat_dzone
    import ahat_pkg::*;
#(
    parameter int AXIS_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AXIS_BITS-1:0] ax,
    input  logic [AXIS_BITS-1:0] ay,
    input  logic [5:0]           half_dz,
    output dz_stat_t             stat
);

    localparam int AW   = 2 * AXIS_BITS + 16;
    localparam int MB   = AXIS_BITS + 6;
    localparam int CNTW = $clog2(MB);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MB - 1);

    localparam logic [1:0] PS_XX    = 2'd0;
    localparam logic [1:0] PS_YY    = 2'd1;
    localparam logic [1:0] PS_SCALE = 2'd2;
    localparam logic [1:0] PS_LIM   = 2'd3;

    logic            busy_reg, busy_next;
    logic [1:0]      pass_reg, pass_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic            center_reg, center_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [AW-1:0]   mc_reg, mc_next;
    logic [MB-1:0]   mr_reg, mr_next;
    logic [AW-1:0]   lhs_reg, lhs_next;
    logic [AXIS_BITS-1:0] ay_reg, ay_next;
    logic [MB-1:0]   hf_reg, hf_next;
    logic [AW-1:0]   acc_sum;

    assign acc_sum = mr_reg[0] ? acc_reg + mc_reg : acc_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        done_next   = done_reg;
        center_next = center_reg;
        acc_next    = acc_reg;
        mc_next     = mc_reg;
        mr_next     = mr_reg;
        lhs_next    = lhs_reg;
        ay_next     = ay_reg;
        hf_next     = hf_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                done_next = 1'b0;
                pass_next = PS_XX;
                cnt_next  = '0;
                acc_next  = '0;
                mc_next   = AW'(ax);
                mr_next   = MB'(ax);
                ay_next   = ay;
                // h * full scale = h * 2^AXIS_BITS - h
                hf_next   = {half_dz, {AXIS_BITS{1'b0}}} - MB'(half_dz);
            end
        end
        else
        begin
            acc_next = acc_sum;
            mc_next  = mc_reg << 1;
            mr_next  = mr_reg >> 1;
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                cnt_next = '0;
                case (pass_reg)
                    PS_XX:
                    begin
                        pass_next = PS_YY;
                        mc_next   = AW'(ay_reg);
                        mr_next   = MB'(ay_reg);
                    end
                    PS_YY:
                    begin
                        pass_next = PS_SCALE;
                        mc_next   = acc_sum;
                        mr_next   = MB'(DZ_SCALE);
                        acc_next  = '0;
                    end
                    PS_SCALE:
                    begin
                        pass_next = PS_LIM;
                        lhs_next  = acc_sum;
                        mc_next   = AW'(hf_reg);
                        mr_next   = hf_reg;
                        acc_next  = '0;
                    end
                    PS_LIM:
                    begin
                        busy_next   = 1'b0;
                        done_next   = 1'b1;
                        center_next = lhs_reg < acc_sum;
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pass_reg <= PS_XX;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pass_reg <= pass_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg <= center_next;
        acc_reg    <= acc_next;
        mc_reg     <= mc_next;
        mr_reg     <= mr_next;
        lhs_reg    <= lhs_next;
        ay_reg     <= ay_next;
        hf_reg     <= hf_next;
    end

    assign stat.done   = done_reg;
    assign stat.center = center_reg;

endmodule

/* sv/ahat_cordic.sv */
module ahat_cordic
    import ahat_pkg::*;
#(
    parameter int AXIS_BITS    = 16,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AXIS_BITS-1:0] p,
    input  logic [AXIS_BITS-1:0] q,
    output cd_stat_t             stat
);

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam logic [ITW-1:0]       IT_LAST = ITW'(CORDIC_STEPS - 1);
    localparam logic [DIG_IDX_W-1:0] DK_LAST = DIG_IDX_W'(NDIG - 1);
    localparam logic [QCNT_W-1:0]    DC_LAST = QCNT_W'(QUOT_BITS - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROT  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic [ITW-1:0]       it_reg, it_next;
    logic [DIG_IDX_W-1:0] dk_reg, dk_next;
    logic [QCNT_W-1:0]    dc_reg, dc_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        vx_reg, vx_next;
    logic [CW-1:0]        vy_reg, vy_next;
    logic [CW-1:0]        z_reg, z_next;
    logic [CW-1:0]        dv_reg, dv_next;
    logic                 cx_reg, cx_next;
    logic                 cy_reg, cy_next;
    logic                 cz_reg, cz_next;
    logic                 dir_reg, dir_next;
    logic                 sx_reg, sx_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;
    logic [DEG_W-1:0]     deg_reg, deg_next;

    logic                 dir;
    logic                 sx;
    logic [DIGIT-1:0]     dx_dig;
    logic [DIGIT-1:0]     dy_dig;
    logic [DIGIT-1:0]     ang_dig;
    logic [CW-1:0]        ang_word;
    logic [DIGIT:0]       sum_x;
    logic [DIGIT:0]       sum_y;
    logic [DIGIT:0]       sum_z;
    logic                 cin_x;
    logic                 cin_y;
    logic                 cin_z;
    logic [POS_W-1:0]     pos;
    logic [BIT_IDX_W-1:0] idx;
    logic [CW-1:0]        rem;
    logic [CW:0]          trial;
    logic                 ge;
    logic [QUOT_BITS-1:0] q_shift;

    // Digit slice of the shifted operands; bits past the top read as the sign
    always_comb
    begin
        pos = '0;
        idx = '0;
        dir = (dk_reg == '0) ? vy_reg[CW-1] : dir_reg;
        sx  = (dk_reg == '0) ? vx_reg[CW-1] : sx_reg;
        for (int j = 0; j < DIGIT; j++)
        begin
            pos = POS_W'(dk_reg) * POS_W'(DIGIT) + POS_W'(it_reg) + POS_W'(j);
            idx = BIT_IDX_W'(it_reg) + BIT_IDX_W'(j);
            if (pos < POS_W'(CW))
            begin
                dx_dig[j] = vy_reg[idx];
                dy_dig[j] = vx_reg[idx];
            end
            else
            begin
                dx_dig[j] = dir;
                dy_dig[j] = sx;
            end
        end
    end

    assign ang_word = atan_step(STEP_IDX_W'(it_reg));
    assign ang_dig  = ang_word[BIT_IDX_W'(dk_reg) * BIT_IDX_W'(DIGIT) +: DIGIT];

    // Subtract as add of the inverse with a carry in on the first digit
    assign cin_x = (dk_reg == '0) ? dir  : cx_reg;
    assign cin_y = (dk_reg == '0) ? ~dir : cy_reg;
    assign cin_z = (dk_reg == '0) ? dir  : cz_reg;

    assign sum_x = {1'b0, vx_reg[DIGIT-1:0]} + {1'b0, dx_dig ^ {DIGIT{dir}}}
                   + (DIGIT+1)'(cin_x);
    assign sum_y = {1'b0, vy_reg[DIGIT-1:0]} + {1'b0, dy_dig ^ {DIGIT{~dir}}}
                   + (DIGIT+1)'(cin_y);
    assign sum_z = {1'b0, z_reg[DIGIT-1:0]} + {1'b0, ang_dig ^ {DIGIT{dir}}}
                   + (DIGIT+1)'(cin_z);

    // Negative angle floors to zero degrees
    assign rem     = z_reg[CW-1] ? '0 : z_reg;
    assign trial   = {1'b0, rem} - {1'b0, dv_reg};
    assign ge      = ~trial[CW];
    assign q_shift = {q_reg[QUOT_BITS-2:0], ge};

    always_comb
    begin
        phase_next = phase_reg;
        it_next    = it_reg;
        dk_next    = dk_reg;
        dc_next    = dc_reg;
        done_next  = done_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        z_next     = z_reg;
        dv_next    = dv_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        dir_next   = dir_reg;
        sx_next    = sx_reg;
        q_next     = q_reg;
        deg_next   = deg_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_ROT;
                    done_next  = 1'b0;
                    it_next    = '0;
                    dk_next    = '0;
                    vx_next    = CW'(p) << VEC_SCALE;
                    vy_next    = CW'(q) << VEC_SCALE;
                    z_next     = '0;
                end
            end
            PH_ROT:
            begin
                vx_next  = {sum_x[DIGIT-1:0], vx_reg[CW-1:DIGIT]};
                vy_next  = {sum_y[DIGIT-1:0], vy_reg[CW-1:DIGIT]};
                z_next   = {sum_z[DIGIT-1:0], z_reg[CW-1:DIGIT]};
                cx_next  = sum_x[DIGIT];
                cy_next  = sum_y[DIGIT];
                cz_next  = sum_z[DIGIT];
                dir_next = dir;
                sx_next  = sx;
                if (dk_reg == DK_LAST)
                begin
                    dk_next = '0;
                    if (it_reg == IT_LAST)
                    begin
                        phase_next = PH_DIV;
                        dc_next    = '0;
                        dv_next    = DIV_TOP;
                    end
                    else
                    begin
                        it_next = it_reg + ITW'(1);
                    end
                end
                else
                begin
                    dk_next = dk_reg + DIG_IDX_W'(1);
                end
            end
            PH_DIV:
            begin
                z_next  = ge ? trial[CW-1:0] : rem;
                q_next  = q_shift;
                dv_next = dv_reg >> 1;
                if (dc_reg == DC_LAST)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                    // clamp to just under 45 degrees
                    if (q_shift > QUOT_BITS'(MAX_PHI_DEG))
                        deg_next = DEG_W'(MAX_PHI_DEG);
                    else
                        deg_next = q_shift[DEG_W-1:0];
                end
                else
                begin
                    dc_next = dc_reg + QCNT_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            it_reg    <= '0;
            dk_reg    <= '0;
            dc_reg    <= '0;
            done_reg  <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            it_reg    <= it_next;
            dk_reg    <= dk_next;
            dc_reg    <= dc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        z_reg   <= z_next;
        dv_reg  <= dv_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        cz_reg  <= cz_next;
        dir_reg <= dir_next;
        sx_reg  <= sx_next;
        q_reg   <= q_next;
        deg_reg <= deg_next;
    end

    assign stat.done = done_reg;
    assign stat.deg  = deg_reg;

endmodule

/* sv/axis_pair_to_hat_angle.sv */
// Keeps the latest X and Y axis positions and turns the pair into a hat
// value after every axis update: 65535 inside the deadzone, else the
// whole-degree angle times 100, taken as atan2 plus 90 so that 0 lies at the
// negative Y end of travel.
// After acceptance a setup state starts both units; the rotation unit then
// runs CORDIC_STEPS steps, working through its 48-bit words eight bits per
// cycle, then extracts whole degrees by restoring division, and the result
// is then loaded into the output register. When the angle is exact (one axis
// centred or equal magnitudes) the rotation is skipped, and the serial
// deadzone multiplier alone sets when the result is ready.
// A new request is taken in the cycle after the result has moved to the
// output register, so no new request is taken while one is in progress.
// A result that waits on hat_ready holds the block. deadzone_size is written
// directly, with no handshake; only while the block is idle is the user to
// write it, as the block itself does not enforce this.
module axis_pair_to_hat_angle
    import ahat_pkg::*;
#(
    parameter int AXIS_BITS    = 16,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        operation,
    input  logic [15:0] axis_value,
    output logic        hat_valid,
    input  logic        hat_ready,
    output logic [15:0] hat_value,
    input  logic        deadzone_we,
    input  logic [6:0]  deadzone_size
);

    localparam logic [AXIS_BITS:0] MID = (AXIS_BITS+1)'((2**AXIS_BITS - 1) / 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    localparam logic OP_X = 1'b0;

    localparam logic [1:0] QD_PP = 2'b00;
    localparam logic [1:0] QD_NP = 2'b10;
    localparam logic [1:0] QD_NN = 2'b11;
    localparam logic [1:0] QD_PN = 2'b01;

    logic [1:0]           state_reg, state_next;
    logic [AXIS_BITS-1:0] x_pos_reg, x_pos_next;
    logic [AXIS_BITS-1:0] y_pos_reg, y_pos_next;
    logic [6:0]           dz_reg, dz_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          hat_reg, hat_next;
    logic                 xneg_reg, yneg_reg;
    logic                 ay0_reg, ax0_reg, eq_reg, ylt_reg;

    logic [AXIS_BITS:0]   xs, ys;
    logic                 xneg_c, yneg_c;
    logic [AXIS_BITS-1:0] ax_c, ay_c;
    logic                 ay0_c, ax0_c, eq_c, ylt_c;
    logic [AXIS_BITS-1:0] cd_p, cd_q;
    logic                 dz_start, cd_start;
    dz_stat_t             dz_stat;
    cd_stat_t             cd_stat;

    logic                 accept;
    logic                 out_free;
    logic                 exact;
    logic [6:0]           fa;
    logic [8:0]           theta;
    logic [8:0]           turn;
    logic [15:0]          hat_angle;
    logic [15:0]          hat_calc;

    // Recentre and split into quadrant and magnitudes
    assign xs     = {1'b0, x_pos_reg} - MID;
    assign ys     = {1'b0, y_pos_reg} - MID;
    assign xneg_c = xs[AXIS_BITS];
    assign yneg_c = ys[AXIS_BITS];
    assign ax_c   = xneg_c ? AXIS_BITS'(-xs) : xs[AXIS_BITS-1:0];
    assign ay_c   = yneg_c ? AXIS_BITS'(-ys) : ys[AXIS_BITS-1:0];
    assign ay0_c  = (ay_c == '0);
    assign ax0_c  = (ax_c == '0);
    assign eq_c   = (ax_c == ay_c);
    assign ylt_c  = (ay_c < ax_c);
    assign cd_p   = ylt_c ? ax_c : ay_c;
    assign cd_q   = ylt_c ? ay_c : ax_c;

    assign dz_start = (state_reg == S_PREP);
    assign cd_start = (state_reg == S_PREP) && !(ay0_c || ax0_c || eq_c);

    ahat_dzone #(
        .AXIS_BITS (AXIS_BITS)
    ) u_dzone (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dz_start),
        .ax      (ax_c),
        .ay      (ay_c),
        .half_dz (dz_reg[6:1]),
        .stat    (dz_stat)
    );

    ahat_cordic #(
        .AXIS_BITS    (AXIS_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .p     (cd_p),
        .q     (cd_q),
        .stat  (cd_stat)
    );

    // Compose the hat angle from quadrant and reference angle
    assign exact = ay0_reg || ax0_reg || eq_reg;

    always_comb
    begin
        if (ay0_reg)
            fa = '0;
        else if (ax0_reg)
            fa = FA_90;
        else if (eq_reg)
            fa = FA_45;
        else if (ylt_reg)
            fa = 7'(cd_stat.deg);
        else
            fa = FA_89 - 7'(cd_stat.deg);
    end

    always_comb
    begin
        case ({xneg_reg, yneg_reg})
            QD_PP:   theta = 9'(fa);
            QD_NP:   theta = ANG_180 - 9'(fa) - 9'(!exact);
            QD_NN:   theta = ANG_180 + 9'(fa);
            QD_PN:   theta = ANG_360 - 9'(fa) - 9'(!exact);
            default: theta = '0;
        endcase
        turn = theta + ANG_90;
        if (turn >= ANG_360)
            turn = turn - ANG_360;
    end

    assign hat_angle = 16'(16'(turn) * HAT_SCALE);
    assign hat_calc  = dz_stat.center ? HAT_CENTER : hat_angle;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || hat_ready;

    always_comb
    begin
        state_next     = state_reg;
        x_pos_next     = x_pos_reg;
        y_pos_next     = y_pos_reg;
        dz_next        = dz_reg;
        hat_next       = hat_reg;
        out_valid_next = out_valid_reg && !hat_ready;
        if (deadzone_we)
            dz_next = deadzone_size;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_X)
                        x_pos_next = axis_value[AXIS_BITS-1:0];
                    else
                        y_pos_next = axis_value[AXIS_BITS-1:0];
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                // hold the result until the output register is free
                if (dz_stat.done && cd_stat.done && out_free)
                begin
                    hat_next       = hat_calc;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_pos_reg     <= MID[AXIS_BITS-1:0];
            y_pos_reg     <= MID[AXIS_BITS-1:0];
            dz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_pos_reg     <= x_pos_next;
            y_pos_reg     <= y_pos_next;
            dz_reg        <= dz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hat_reg <= hat_next;
        if (state_reg == S_PREP)
        begin
            xneg_reg <= xneg_c;
            yneg_reg <= yneg_c;
            ay0_reg  <= ay0_c;
            ax0_reg  <= ax0_c;
            eq_reg   <= eq_c;
            ylt_reg  <= ylt_c;
        end
    end

    assign hat_valid = out_valid_reg;
    assign hat_value = hat_reg;

endmodule

/* dv/axis_pair_to_hat_angle_tb.sv */
`timescale 1ns / 100ps

module axis_pair_to_hat_angle_tb;
    import ahat_pkg::*;

    localparam logic   OP_X       = 1'b0;
    localparam logic   OP_Y       = 1'b1;
    localparam int     AXIS_MID   = 32767;
    localparam longint AXIS_FULL  = 65535;
    localparam int     ROT_STEPS  = 24;
    localparam longint DEG_UNITS  = 64'd1000000000000;
    localparam longint RAD_DEG    = 64'd57295779513082;
    localparam int     PHASES     = 7;
    localparam int     PHASE_REQS = 245;
    localparam int     SETTLE_CYC = 200;
    localparam int     MAX_SHOWN  = 10;

    typedef struct packed {
        logic        op;
        logic [15:0] value;
    } axis_req_t;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        item_valid       = 1'b0;
    logic        item_ready;
    logic        operation        = OP_X;
    logic [15:0] axis_value       = '0;
    logic        hat_valid;
    logic        hat_ready        = 1'b0;
    logic [15:0] hat_value;
    logic        deadzone_we      = 1'b0;
    logic [6:0]  deadzone_size    = '0;

    axis_req_t   axis_reqs[$];
    logic [15:0] hat_expected[$];
    axis_req_t   next_req;
    logic [15:0] want_hat;

    // Predictor state
    logic [15:0] x_pos  = 16'(AXIS_MID);
    logic [15:0] y_pos  = 16'(AXIS_MID);
    logic [6:0]  dz_reg = '0;

    // Positions as the stimulus generator sees them
    logic [15:0] gen_x;
    logic [15:0] gen_y;

    logic req_taken  = 1'b0;
    bit   tx_idle_en = 1'b0;
    bit   rx_idle_en = 1'b0;
    int   tx_gap     = 0;
    int   rx_stall   = 0;
    int   errors     = 0;

    axis_pair_to_hat_angle #(
        .AXIS_BITS    (16),
        .CORDIC_STEPS (ROT_STEPS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .operation        (operation),
        .axis_value       (axis_value),
        .hat_valid        (hat_valid),
        .hat_ready        (hat_ready),
        .hat_value        (hat_value),
        .deadzone_we      (deadzone_we),
        .deadzone_size    (deadzone_size)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    // atan(2^-i) in units of 1e-12 degree
    function automatic longint rot_step_angle(input int i);
        case (i)
            0:       return 64'd45000000000000;
            1:       return 64'd26565051177078;
            2:       return 64'd14036243467926;
            3:       return 64'd7125016348902;
            4:       return 64'd3576334374997;
            5:       return 64'd1789910608246;
            6:       return 64'd895173710211;
            7:       return 64'd447614170861;
            8:       return 64'd223810500369;
            9:       return 64'd111905677066;
            10:      return 64'd55952891894;
            11:      return 64'd27976452617;
            12:      return 64'd13988227142;
            13:      return 64'd6994113675;
            14:      return 64'd3497056851;
            15:      return 64'd1748528427;
            default: return (RAD_DEG + (64'sd1 <<< (i - 1))) >>> i;
        endcase
    endfunction

    // Whole degrees of atan(q / p) for 0 < q < p, by vectoring rotation
    function automatic int phi_floor_deg(input longint p, input longint q);
        longint vx, vy, z, dx, dy;
        vx = p <<< VEC_SCALE;
        vy = q <<< VEC_SCALE;
        z  = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + rot_step_angle(i);
            end
            else
            begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - rot_step_angle(i);
            end
        end
        if (z < 1)
            z = 1;
        if (z > 45 * DEG_UNITS - 1)
            z = 45 * DEG_UNITS - 1;
        return int'(z / DEG_UNITS);
    endfunction

    function automatic logic [15:0] hat_from_axes(input logic [15:0] xp,
                                                  input logic [15:0] yp,
                                                  input logic [6:0]  dz);
        longint x, y, h, ax, ay, lhs, rhs;
        int     fa, theta, base;
        bit     exact, neg;
        x   = longint'(xp) - AXIS_MID;
        y   = longint'(yp) - AXIS_MID;
        h   = longint'(dz >> 1);
        lhs = 10000 * (x * x + y * y);
        rhs = h * h * AXIS_FULL * AXIS_FULL;
        if (lhs < rhs)
            return HAT_CENTER;
        // atan2(0, 0) counts as zero degrees
        theta = 0;
        if (x != 0 || y != 0)
        begin
            ax    = (x < 0) ? -x : x;
            ay    = (y < 0) ? -y : y;
            exact = 1'b1;
            if (ay == 0)
                fa = 0;
            else if (ax == 0)
                fa = 90;
            else if (ax == ay)
                fa = 45;
            else
            begin
                exact = 1'b0;
                fa = (ay < ax) ? phi_floor_deg(ax, ay) : 89 - phi_floor_deg(ay, ax);
            end
            if (x >= 0 && y >= 0)
            begin
                base = 0;
                neg  = 1'b0;
            end
            else if (x < 0 && y >= 0)
            begin
                base = 180;
                neg  = 1'b1;
            end
            else if (x < 0)
            begin
                base = 180;
                neg  = 1'b0;
            end
            else
            begin
                base = 360;
                neg  = 1'b1;
            end
            // an inexact angle taken off a base floors one degree lower
            if (!neg)
                theta = base + fa;
            else if (exact)
                theta = base - fa;
            else
                theta = base - 1 - fa;
            theta = theta % 360;
        end
        return 16'(((theta + 90) % 360) * 100);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 200);
    endfunction

    // Request driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || req_taken))
        begin
            if (tx_gap > 0)
            begin
                item_valid <= 1'b0;
                tx_gap = tx_gap - 1;
            end
            else if (axis_reqs.size() > 0)
            begin
                next_req = axis_reqs.pop_front();
                item_valid <= 1'b1;
                operation  <= next_req.op;
                axis_value <= next_req.value;
                tx_gap = tx_idle_en ? idle_len() : 0;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                hat_ready <= 1'b0;
                rx_stall = rx_stall - 1;
            end
            else
            begin
                hat_ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 7) == 0)
                    rx_stall = idle_len();
            end
        end
    end

    // Check results first, then predict for a request taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hat_valid && hat_ready)
            begin
                if (hat_expected.size() == 0)
                begin
                    if (errors < MAX_SHOWN)
                        $display("%0t: unexpected hat result %0d", $realtime, hat_value);
                    errors++;
                end
                else
                begin
                    want_hat = hat_expected.pop_front();
                    if (hat_value !== want_hat)
                    begin
                        if (errors < MAX_SHOWN)
                            $display("%0t: hat mismatch: expected %0d, got %0d",
                                     $realtime, want_hat, hat_value);
                        errors++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                if (operation == OP_X)
                    x_pos = axis_value;
                else
                    y_pos = axis_value;
                hat_expected.push_back(hat_from_axes(x_pos, y_pos, dz_reg));
            end
            req_taken <= item_valid && item_ready;
        end
    end

    task automatic queue_axis(input logic op, input logic [15:0] value);
        axis_req_t req;
        req.op    = op;
        req.value = value;
        while (axis_reqs.size() > 3)
            @(posedge clk);
        axis_reqs.push_back(req);
        if (op == OP_X)
            gen_x = value;
        else
            gen_y = value;
    endtask

    task automatic queue_random_axis();
        logic        op;
        logic [15:0] value;
        int          other, mag;
        op    = 1'($urandom_range(0, 1));
        other = (op == OP_X) ? int'(gen_y) : int'(gen_x);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = 16'($urandom);
            4:          value = 16'(AXIS_MID + $urandom_range(0, 128) - 64);
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       value = 16'd0;
                    1:       value = 16'd65535;
                    2:       value = 16'd32767;
                    3:       value = 16'd32768;
                    default: value = 16'd32766;
                endcase
            end
            6, 7:
            begin
                // land on or next to the diagonal
                mag = other - AXIS_MID;
                if (mag < 0)
                    mag = -mag;
                mag = mag + int'($urandom_range(0, 4)) - 2;
                if (mag < 0)
                    mag = 0;
                if (mag > AXIS_MID + 1)
                    mag = AXIS_MID + 1;
                if (mag <= AXIS_MID && $urandom_range(0, 1) == 1)
                    value = 16'(AXIS_MID - mag);
                else
                    value = 16'(AXIS_MID + mag);
            end
            8:          value = 16'(AXIS_MID + $urandom_range(0, 2) - 1);
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    value = 16'(AXIS_MID + $urandom_range(0, 32768));
                else
                    value = 16'(AXIS_MID - $urandom_range(0, 32767));
            end
        endcase
        queue_axis(op, value);
    endtask

    // Hold until every request has been answered
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (axis_reqs.size() != 0 || item_valid || hat_expected.size() != 0);
    endtask

    task automatic set_deadzone(input logic [6:0] dz);
        @(negedge clk);
        deadzone_we   <= 1'b1;
        deadzone_size <= dz;
        @(negedge clk);
        deadzone_we <= 1'b0;
        dz_reg = dz;
    endtask

    initial
    begin
        logic [6:0] dz_plan [PHASES];
        dz_plan = '{7'd0, 7'd127, 7'd2, 7'd50, 7'd100, 7'd1, 7'd99};
        dz_plan[PHASES-1] = 7'($urandom_range(0, 127));
        gen_x = 16'(AXIS_MID);
        gen_y = 16'(AXIS_MID);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_deadzone(7'd0);
        queue_axis(OP_X, 16'd32767);
        queue_axis(OP_X, 16'd65535);
        queue_axis(OP_Y, 16'd65535);
        queue_axis(OP_X, 16'd0);
        queue_axis(OP_Y, 16'd0);
        queue_axis(OP_X, 16'd32767);
        queue_axis(OP_X, 16'd65535);
        queue_axis(OP_Y, 16'd32767);
        queue_axis(OP_Y, 16'd32768);
        queue_axis(OP_Y, 16'd32766);
        queue_axis(OP_X, 16'd32768);
        queue_axis(OP_X, 16'hAAAA);
        queue_axis(OP_Y, 16'h5555);
        settle();

        // boundary of a 50% deadzone sits half a count beyond 32767
        set_deadzone(7'd100);
        queue_axis(OP_X, 16'd32767);
        queue_axis(OP_Y, 16'd32767);
        queue_axis(OP_X, 16'd52767);
        queue_axis(OP_X, 16'd65535);
        settle();

        set_deadzone(7'd127);
        queue_axis(OP_X, 16'd0);
        queue_axis(OP_Y, 16'd0);
        settle();

        set_deadzone(7'd1);
        queue_axis(OP_X, 16'd32767);
        queue_axis(OP_Y, 16'd32767);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            set_deadzone(dz_plan[ph]);
            tx_idle_en = (ph != 1);
            rx_idle_en = (ph != 1 && ph != 3);
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if ($urandom_range(0, 149) == 0)
                    settle();
                queue_random_axis();
            end
        end

        settle();
        repeat (SETTLE_CYC) @(posedge clk);
        if (errors == 0 && hat_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* axis_pair_to_hat_angle.f */
sv/ahat_pkg.sv
sv/ahat_dzone.sv
sv/ahat_cordic.sv
sv/axis_pair_to_hat_angle.sv
dv/axis_pair_to_hat_angle_tb.sv
